### hdl/awst_pkg.sv
// Package: shared widths, codes and control structs of the availability-window sync tracker.
`default_nettype none
package awst_pkg;

    // Time base
    localparam int TIME_BITS  = 64;
    localparam int NOW_W      = 64;
    localparam int US_SHIFT   = 10;
    localparam int TU_W       = TIME_BITS - US_SHIFT;

    // Field widths
    localparam int OP_W       = 2;
    localparam int PERIOD_W   = 10;
    localparam int WINDOWS_W  = 5;
    localparam int EXT_W      = 14;
    localparam int PEER_W     = 16;
    localparam int WIN_CNT_W  = 16;
    localparam int NEXT_US_W  = 24;
    localparam int ERR_W      = 32;
    localparam int DIV_CNT_W  = $clog2(TU_W + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS = 2'd1;

    localparam logic [PERIOD_W-1:0]  RESET_PERIOD  = 10'd16;
    localparam logic [WINDOWS_W-1:0] RESET_WINDOWS = 5'd4;
    localparam logic [WINDOWS_W-1:0] MAX_WINDOWS   = 5'd16;
    localparam logic [WIN_CNT_W-1:0] COUNTER_KEEP_MASK = 16'hfffc;

    // Largest extended window, in TU and in microseconds
    localparam int MAX_EXT_TU = 1023 * 16;
    localparam int MAX_EXT_US = MAX_EXT_TU * 1024;

    // Opcodes
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT   = 2'd2;

    typedef struct packed {
        logic [PERIOD_W-1:0]  period;
        logic [WINDOWS_W-1:0] windows;
    } cfg_eff_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

### hdl/awst_if.sv
// Interfaces: item and result channels of the sync tracker.
`default_nettype none
interface awst_in_if;
    logic                            valid;
    logic                            ready;
    logic [awst_pkg::OP_W-1:0]       opcode;
    logic [awst_pkg::NOW_W-1:0]      now_us;
    logic [awst_pkg::PEER_W-1:0]     peer_time_to_next_tu;
    logic [awst_pkg::PEER_W-1:0]     peer_counter;

    modport source (output valid, output opcode, output now_us,
                    output peer_time_to_next_tu, output peer_counter, input ready);
    modport sink   (input valid, input opcode, input now_us,
                    input peer_time_to_next_tu, input peer_counter, output ready);
endinterface

interface awst_out_if;
    logic                              valid;
    logic                              ready;
    logic [awst_pkg::PEER_W-1:0]       next_window_tu;
    logic [awst_pkg::NEXT_US_W-1:0]    next_window_us;
    logic [awst_pkg::WIN_CNT_W-1:0]    current_window;
    logic [awst_pkg::WIN_CNT_W-1:0]    current_extended;
    logic signed [awst_pkg::ERR_W-1:0] sync_error_tu;

    modport source (output valid, output next_window_tu, output next_window_us,
                    output current_window, output current_extended,
                    output sync_error_tu, input ready);
    modport sink   (input valid, input next_window_tu, input next_window_us,
                    input current_window, input current_extended,
                    input sync_error_tu, output ready);
endinterface
`default_nettype wire

### hdl/awst_cfg.sv
// Configuration registers with the clamped period and window count they imply.
`default_nettype none
module awst_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [awst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [awst_pkg::CFG_DATA_W-1:0] cfg_data,
    output awst_pkg::cfg_eff_t                   eff
);

    logic [awst_pkg::PERIOD_W-1:0]  period_reg;
    logic [awst_pkg::WINDOWS_W-1:0] windows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= awst_pkg::RESET_PERIOD;
            windows_reg <= awst_pkg::RESET_WINDOWS;
        end
        else if (cfg_we)
        begin
            if (cfg_index == awst_pkg::CFG_PERIOD)
            begin
                period_reg <= cfg_data[awst_pkg::PERIOD_W-1:0];
            end
            else if (cfg_index == awst_pkg::CFG_WINDOWS)
            begin
                windows_reg <= cfg_data[awst_pkg::WINDOWS_W-1:0];
            end
        end
    end

    // Treat a zero period as one; clamp the window count into one to sixteen
    always_comb
    begin
        eff.period = (period_reg == '0) ? awst_pkg::PERIOD_W'(1) : period_reg;
        if (windows_reg == '0)
        begin
            eff.windows = awst_pkg::WINDOWS_W'(1);
        end
        else if (windows_reg > awst_pkg::MAX_WINDOWS)
        begin
            eff.windows = awst_pkg::MAX_WINDOWS;
        end
        else
        begin
            eff.windows = windows_reg;
        end
    end

endmodule
`default_nettype wire

### hdl/awst_div.sv
// Shared restoring divider: one quotient bit per cycle, dividend aligned at the top.
`default_nettype none
module awst_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire awst_pkg::div_ctrl_t          ctrl,
    input  wire logic [awst_pkg::TU_W-1:0]    dividend,
    input  wire logic [awst_pkg::EXT_W-1:0]   divisor,
    output awst_pkg::div_stat_t               stat,
    output logic      [awst_pkg::TU_W-1:0]    quotient,
    output logic      [awst_pkg::EXT_W-1:0]   remainder
);

    logic                           busy_reg,  busy_next;
    logic                           done_reg,  done_next;
    logic [awst_pkg::DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [awst_pkg::TU_W-1:0]      dvd_reg,   dvd_next;
    logic [awst_pkg::EXT_W-1:0]     rem_reg,   rem_next;
    logic [awst_pkg::EXT_W-1:0]     dsr_reg,   dsr_next;
    logic [awst_pkg::EXT_W:0]       trial;
    logic [awst_pkg::EXT_W:0]       diff;
    logic                           fits;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[awst_pkg::TU_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;

        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ctrl.nbits;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[awst_pkg::EXT_W-1:0] : trial[awst_pkg::EXT_W-1:0];
            dvd_next = {dvd_reg[awst_pkg::TU_W-2:0], fits};
            cnt_next = cnt_reg - awst_pkg::DIV_CNT_W'(1);
            if (cnt_reg == awst_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

### hdl/availability_window_sync_tracker.sv
// Top level: availability-window sync tracker, sequencer around one shared divider.
//
//  channel   dir   handshake     payload
//  -------   ---   -----------   --------------------------------------------------
//  item      in    valid/ready   opcode, now_us, peer_time_to_next_tu, peer_counter
//  result    out   valid/ready   next_window_tu, next_window_us, current_window,
//                                current_extended, sync_error_tu
//  cfg       in    cfg_we        cfg_index, cfg_data (no read-back)
//
// One item runs from transfer to transfer through four divider passes of TU_W, 14, 16
// and 16 quotient bits, plus setup and finish steps.
// Reset clears the anchor, the window counter, the sequencer and the result valid flag;
// the configuration returns to a 16 TU period and 4 windows.
// item.ready is high only in idle. A finished result waits in the output register while
// the next item is taken; that item stalls at its finish step until the register frees.
`default_nettype none
module availability_window_sync_tracker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    awst_in_if.sink                              item,
    awst_out_if.source                           result,
    input  wire logic                            cfg_we,
    input  wire logic [awst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [awst_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int TB   = awst_pkg::TIME_BITS;
    localparam int TUW  = awst_pkg::TU_W;
    localparam int EW   = awst_pkg::EXT_W;
    localparam int WW   = awst_pkg::WINDOWS_W;
    localparam int CW   = awst_pkg::WIN_CNT_W;
    localparam int PRW  = awst_pkg::PEER_W;
    localparam int USW  = awst_pkg::NEXT_US_W;
    localparam int ERW  = awst_pkg::ERR_W;
    localparam int SH   = awst_pkg::US_SHIFT;

    // Sequencer states
    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_EXT  = 14'b00000000000010,
        S_ANCH = 14'b00000000000100,
        S_LT   = 14'b00000000001000,
        S_WT   = 14'b00000000010000,
        S_LP   = 14'b00000000100000,
        S_WP   = 14'b00000001000000,
        S_WIN  = 14'b00000010000000,
        S_LW   = 14'b00000100000000,
        S_WW   = 14'b00001000000000,
        S_LC   = 14'b00010000000000,
        S_WC   = 14'b00100000000000,
        S_ERR  = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    awst_pkg::cfg_eff_t eff;

    awst_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eff       (eff)
    );

    // Shared divider
    awst_pkg::div_ctrl_t div_ctrl;
    awst_pkg::div_stat_t div_stat;
    logic [TUW-1:0] div_dvd;
    logic [EW-1:0]  div_dsr;
    logic [TUW-1:0] div_quot;
    logic [EW-1:0]  div_rem;

    awst_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Tracked state
    logic [TB-1:0] anchor_reg,  anchor_next;
    logic [CW-1:0] counter_reg, counter_next;

    // Captured item and working values
    logic [awst_pkg::OP_W-1:0] op_reg,        op_next;
    logic [TB-1:0]             now_reg,       now_next;
    logic [PRW-1:0]            peer_next_reg, peer_next_next;
    logic [PRW-1:0]            peer_cnt_reg,  peer_cnt_next;
    logic [EW-1:0]             ext_reg,       ext_next;
    logic [SH-1:0]             low_us_reg,    low_us_next;
    logic [CW-1:0]             q16_reg,       q16_next;
    logic [EW-1:0]             in_ext_reg,    in_ext_next;
    logic [WW-1:0]             qp_reg,        qp_next;
    logic [CW-1:0]             cur_win_reg,   cur_win_next;
    logic [CW-1:0]             cur_ext_reg,   cur_ext_next;
    logic [CW-1:0]             pcw_reg,       pcw_next;
    logic signed [ERW-1:0]     prod_reg,      prod_next;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic [PRW-1:0]        out_tu_reg,    out_tu_next;
    logic [USW-1:0]        out_us_reg,    out_us_next;
    logic [CW-1:0]         out_win_reg,   out_win_next;
    logic [CW-1:0]         out_ext_reg,   out_ext_next;
    logic signed [ERW-1:0] out_err_reg,   out_err_next;

    // Combinational helpers
    logic [TB-1:0]         since_us;
    logic signed [PRW:0]   back_tu;
    logic [TB-1:0]         back_us;
    logic [WW+CW-1:0]      wq;
    logic signed [CW:0]    ext_diff;
    logic signed [ERW-1:0] ext_prod;
    logic [EW-1:0]         next_tu;
    logic signed [PRW:0]   tu_diff;
    logic                  load_out;

    always_comb
    begin
        since_us = now_reg - anchor_reg;
        back_tu  = $signed({{(PRW + 1 - EW){1'b0}}, ext_reg}) - $signed({1'b0, peer_next_reg});
        back_us  = TB'(back_tu) <<< SH;
        wq       = (WW + CW)'(eff.windows) * (WW + CW)'(q16_reg);
        ext_diff = $signed({1'b0, pcw_reg}) - $signed({1'b0, cur_ext_reg});
        ext_prod = ERW'(ext_diff) * ERW'($signed({1'b0, ext_reg}));
        next_tu  = ext_reg - in_ext_reg;
        tu_diff  = $signed({1'b0, peer_next_reg}) - $signed({{(PRW + 1 - EW){1'b0}}, next_tu});
        load_out = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

        state_next     = state_reg;
        anchor_next    = anchor_reg;
        counter_next   = counter_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        peer_next_next = peer_next_reg;
        peer_cnt_next  = peer_cnt_reg;
        ext_next       = ext_reg;
        low_us_next    = low_us_reg;
        q16_next       = q16_reg;
        in_ext_next    = in_ext_reg;
        qp_next        = qp_reg;
        cur_win_next   = cur_win_reg;
        cur_ext_next   = cur_ext_reg;
        pcw_next       = pcw_reg;
        prod_next      = prod_reg;

        div_ctrl.start = 1'b0;
        div_ctrl.nbits = awst_pkg::DIV_CNT_W'(TUW);
        div_dvd        = since_us[TB-1:SH];
        div_dsr        = ext_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    op_next        = item.opcode;
                    now_next       = item.now_us[TB-1:0];
                    peer_next_next = item.peer_time_to_next_tu;
                    peer_cnt_next  = item.peer_counter;
                    state_next     = S_EXT;
                end
            end
            S_EXT:
            begin
                // extended period in TU
                ext_next   = EW'(eff.period) * EW'(eff.windows);
                state_next = S_ANCH;
            end
            S_ANCH:
            begin
                // re-anchor on update or init, keep on query and the unused code
                unique case (op_reg)
                    awst_pkg::OP_UPDATE:
                    begin
                        anchor_next  = now_reg - back_us;
                        counter_next = peer_cnt_reg & awst_pkg::COUNTER_KEEP_MASK;
                    end
                    awst_pkg::OP_INIT:
                    begin
                        anchor_next  = now_reg;
                        counter_next = '0;
                    end
                    default:
                    begin
                        anchor_next  = anchor_reg;
                        counter_next = counter_reg;
                    end
                endcase
                state_next = S_LT;
            end
            S_LT:
            begin
                // elapsed TU over the extended period
                div_ctrl.start = 1'b1;
                low_us_next    = since_us[SH-1:0];
                state_next     = S_WT;
            end
            S_WT:
            begin
                if (div_stat.done)
                begin
                    q16_next    = div_quot[CW-1:0];
                    in_ext_next = div_rem;
                    state_next  = S_LP;
                end
            end
            S_LP:
            begin
                // position inside the extended window over the period
                div_ctrl.start = 1'b1;
                div_ctrl.nbits = awst_pkg::DIV_CNT_W'(EW);
                div_dvd        = {in_ext_reg, {(TUW - EW){1'b0}}};
                div_dsr        = EW'(eff.period);
                state_next     = S_WP;
            end
            S_WP:
            begin
                if (div_stat.done)
                begin
                    qp_next    = div_quot[WW-1:0];
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                cur_win_next = counter_reg + CW'(qp_reg) + wq[CW-1:0];
                state_next   = S_LW;
            end
            S_LW:
            begin
                div_ctrl.start = 1'b1;
                div_ctrl.nbits = awst_pkg::DIV_CNT_W'(CW);
                div_dvd        = {cur_win_reg, {(TUW - CW){1'b0}}};
                div_dsr        = EW'(eff.windows);
                state_next     = S_WW;
            end
            S_WW:
            begin
                if (div_stat.done)
                begin
                    cur_ext_next = div_quot[CW-1:0];
                    state_next   = S_LC;
                end
            end
            S_LC:
            begin
                div_ctrl.start = 1'b1;
                div_ctrl.nbits = awst_pkg::DIV_CNT_W'(PRW);
                div_dvd        = {peer_cnt_reg, {(TUW - PRW){1'b0}}};
                div_dsr        = EW'(eff.windows);
                state_next     = S_WC;
            end
            S_WC:
            begin
                if (div_stat.done)
                begin
                    pcw_next   = div_quot[CW-1:0];
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                prod_next  = ext_prod;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_tu_next    = out_tu_reg;
        out_us_next    = out_us_reg;
        out_win_next   = out_win_reg;
        out_ext_next   = out_ext_reg;
        out_err_next   = out_err_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_tu_next    = PRW'(next_tu);
            out_us_next    = {ext_reg, {SH{1'b0}}} - {in_ext_reg, low_us_reg};
            out_win_next   = cur_win_reg;
            out_ext_next   = cur_ext_reg;
            out_err_next   = prod_reg - ERW'(tu_diff);
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            anchor_reg    <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            anchor_reg    <= anchor_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        now_reg       <= now_next;
        peer_next_reg <= peer_next_next;
        peer_cnt_reg  <= peer_cnt_next;
        ext_reg       <= ext_next;
        low_us_reg    <= low_us_next;
        q16_reg       <= q16_next;
        in_ext_reg    <= in_ext_next;
        qp_reg        <= qp_next;
        cur_win_reg   <= cur_win_next;
        cur_ext_reg   <= cur_ext_next;
        pcw_reg       <= pcw_next;
        prod_reg      <= prod_next;
        out_tu_reg    <= out_tu_next;
        out_us_reg    <= out_us_next;
        out_win_reg   <= out_win_next;
        out_ext_reg   <= out_ext_next;
        out_err_reg   <= out_err_next;
    end

    // Take a transfer only while the sequencer idles
    assign item.ready              = (state_reg == S_IDLE);
    assign result.valid            = out_valid_reg;
    assign result.next_window_tu   = out_tu_reg;
    assign result.next_window_us   = out_us_reg;
    assign result.current_window   = out_win_reg;
    assign result.current_extended = out_ext_reg;
    assign result.sync_error_tu    = out_err_reg;

endmodule
`default_nettype wire

### hdl/awst_checker.sv
// Checker: port-level properties of the sync tracker, bound to the top level.
`default_nettype none
module awst_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                item_valid,
    input wire logic                                item_ready,
    input wire logic                                result_valid,
    input wire logic                                result_ready,
    input wire logic [awst_pkg::PEER_W-1:0]         next_window_tu,
    input wire logic [awst_pkg::NEXT_US_W-1:0]      next_window_us,
    input wire logic [awst_pkg::WIN_CNT_W-1:0]      current_window,
    input wire logic signed [awst_pkg::ERR_W-1:0]   sync_error_tu
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(next_window_tu) && $stable(next_window_us)
             && $stable(current_window) && $stable(sync_error_tu)))
    else $error("stalled result changed");

    // An accepted item keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
    else $error("item taken while the previous one is still in work");

    // Time to the next extended window in TU lies in one to the longest extended period
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (next_window_tu != '0
                          && next_window_tu <= awst_pkg::PEER_W'(awst_pkg::MAX_EXT_TU)))
    else $error("next_window_tu out of range");

    // Time to the next extended window in microseconds lies in range too
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (next_window_us != '0
                          && next_window_us <= awst_pkg::NEXT_US_W'(awst_pkg::MAX_EXT_US)))
    else $error("next_window_us out of range");

endmodule

bind availability_window_sync_tracker awst_checker u_awst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .next_window_tu (result.next_window_tu),
    .next_window_us (result.next_window_us),
    .current_window (result.current_window),
    .sync_error_tu  (result.sync_error_tu)
);
`default_nettype wire

### tb/sv/availability_window_sync_tracker_test.sv
// Testbench: availability-window sync tracker checked against its own window predictor.
`default_nettype none
module availability_window_sync_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcode 3 has no name in the package; it must act as a query.
    localparam logic [awst_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    // One result of the block, field by field.
    typedef struct packed {
        logic [awst_pkg::PEER_W-1:0]       next_tu;
        logic [awst_pkg::NEXT_US_W-1:0]    next_us;
        logic [awst_pkg::WIN_CNT_W-1:0]    window;
        logic [awst_pkg::WIN_CNT_W-1:0]    extended;
        logic signed [awst_pkg::ERR_W-1:0] error_tu;
    } window_report_t;

    logic clk;
    logic rst_n;
    logic                            cfg_we;
    logic [awst_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [awst_pkg::CFG_DATA_W-1:0] cfg_data;

    awst_in_if  item_ch ();
    awst_out_if result_ch ();

    availability_window_sync_tracker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers and of the tracking state.
    logic [awst_pkg::PERIOD_W-1:0]  shadow_period;
    logic [awst_pkg::WINDOWS_W-1:0] shadow_windows;
    logic [awst_pkg::NOW_W-1:0]     shadow_anchor_us;
    logic [awst_pkg::WIN_CNT_W-1:0] shadow_counter;

    // Reports predicted at each accepted transfer, oldest first.
    window_report_t pending_reports[$];

    int  mismatch_count;
    bit  steady_flow;          // set: neither side idles
    logic [awst_pkg::NOW_W-1:0] time_cursor;

    // Clock: 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a correct run needs about 2 ms; stop well after that.
    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Effective period and window count, with zero and oversize values folded in.
    function automatic logic [63:0] eff_period();
        return (shadow_period == 0) ? 64'd1 : 64'(shadow_period);
    endfunction

    function automatic logic [63:0] eff_windows();
        if (shadow_windows == 0)
            return 64'd1;
        if (shadow_windows > awst_pkg::MAX_WINDOWS)
            return 64'(awst_pkg::MAX_WINDOWS);
        return 64'(shadow_windows);
    endfunction

    // Apply one item to the predicted state and work out its report.
    function automatic window_report_t track_window(
        input logic [awst_pkg::OP_W-1:0]   op,
        input logic [awst_pkg::NOW_W-1:0]  now,
        input logic [awst_pkg::PEER_W-1:0] peer_next,
        input logic [awst_pkg::PEER_W-1:0] peer_cnt);
        logic [63:0] p, w, ext_tu, ext_us, since_us, since_tu, in_ext;
        logic [63:0] next_tu, next_us, cur_win, cur_ext;
        longint ext_diff, err;
        window_report_t rep;
        p = eff_period();
        w = eff_windows();
        ext_tu = p * w;
        ext_us = ext_tu << awst_pkg::US_SHIFT;
        if (op == awst_pkg::OP_UPDATE)
        begin
            // A peer value above the extended period moves the anchor forward.
            shadow_anchor_us = now - ((ext_tu - {48'd0, peer_next}) << awst_pkg::US_SHIFT);
            shadow_counter   = peer_cnt & awst_pkg::COUNTER_KEEP_MASK;
        end
        else if (op == awst_pkg::OP_INIT)
        begin
            shadow_anchor_us = now;
            shadow_counter   = '0;
        end
        since_us = now - shadow_anchor_us;
        since_tu = since_us >> awst_pkg::US_SHIFT;
        in_ext   = since_tu % ext_tu;
        next_tu  = ext_tu - in_ext;
        next_us  = ext_us - (since_us % ext_us);
        cur_win  = ({48'd0, shadow_counter} + in_ext / p + w * (since_tu / ext_tu))
                   & 64'hffff;
        cur_ext  = cur_win / w;
        ext_diff = longint'({48'd0, peer_cnt} / w) - longint'(cur_ext);
        err = ext_diff * longint'(ext_tu)
              - (longint'({48'd0, peer_next}) - longint'(next_tu & 64'hffff));
        rep.next_tu  = next_tu[15:0];
        rep.next_us  = next_us[23:0];
        rep.window   = cur_win[15:0];
        rep.extended = cur_ext[15:0];
        rep.error_tu = err[31:0];
        return rep;
    endfunction

    function automatic int draw_gap();
        return steady_flow ? 0 : $urandom_range(0, 7);
    endfunction

    // Offer one item after a random gap; predict its report on the transfer.
    // Valid is lowered only when a gap follows, so it never drops and rises in one step.
    task automatic send_item(input logic [awst_pkg::OP_W-1:0]   op,
                             input logic [awst_pkg::NOW_W-1:0]  now,
                             input logic [awst_pkg::PEER_W-1:0] peer_next,
                             input logic [awst_pkg::PEER_W-1:0] peer_cnt);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid                <= 1'b1;
        item_ch.opcode               <= op;
        item_ch.now_us               <= now;
        item_ch.peer_time_to_next_tu <= peer_next;
        item_ch.peer_counter         <= peer_cnt;
        do
            @(posedge clk);
        while (!item_ch.ready);
        pending_reports.push_back(track_window(op, now, peer_next, peer_cnt));
    endtask

    // Drop valid and hold until every outstanding report has come back.
    task automatic drain_block();
        item_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers on consecutive edges; the block must be idle.
    task automatic apply_setting(input logic [awst_pkg::CFG_DATA_W-1:0] period_data,
                                 input logic [awst_pkg::CFG_DATA_W-1:0] windows_data);
        drain_block();
        cfg_we    <= 1'b1;
        cfg_index <= awst_pkg::CFG_PERIOD;
        cfg_data  <= period_data;
        @(posedge clk);
        shadow_period = period_data[awst_pkg::PERIOD_W-1:0];
        cfg_index <= awst_pkg::CFG_WINDOWS;
        cfg_data  <= windows_data;
        @(posedge clk);
        shadow_windows = windows_data[awst_pkg::WINDOWS_W-1:0];
        cfg_we <= 1'b0;
    endtask

    task automatic note_failure(input string what, input window_report_t want,
                                input window_report_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected tu=%0d us=%0d win=%0d ext=%0d err=%0d,",
                     what, want.next_tu, want.next_us, want.window, want.extended,
                     want.error_tu,
                     " got tu=%0d us=%0d win=%0d ext=%0d err=%0d",
                     got.next_tu, got.next_us, got.window, got.extended,
                     got.error_tu);
    endtask

    // Result side: stall at random, then compare each transfer with the oldest prediction.
    initial
    begin : result_checker
        int stall;
        window_report_t got;
        window_report_t want;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            got.next_tu  = result_ch.next_window_tu;
            got.next_us  = result_ch.next_window_us;
            got.window   = result_ch.current_window;
            got.extended = result_ch.current_extended;
            got.error_tu = result_ch.sync_error_tu;
            if (pending_reports.size() == 0)
                note_failure("unexpected result", '0, got);
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want)
                    note_failure("mismatch", want, got);
            end
        end
    end

    // Reset values, opcode 3, extreme times and the wrap of now behind the anchor.
    task automatic test_reset_defaults();
        send_item(awst_pkg::OP_QUERY, 64'd0, 16'd0, 16'd0);
        send_item(awst_pkg::OP_QUERY, 64'hffff_ffff_ffff_ffff, 16'hffff, 16'hffff);
        send_item(OP_SPARE, 64'd12345, 16'd40, 16'd7);
        send_item(awst_pkg::OP_INIT, 64'h8000_0000_0000_0000, 16'd3, 16'd9);
        // Now lies before the anchor: the difference wraps.
        send_item(awst_pkg::OP_QUERY, 64'h7fff_ffff_ffff_f000, 16'd10, 16'd100);
        send_item(awst_pkg::OP_QUERY, 64'h8000_0000_0001_0000, 16'd64, 16'd4);
    endtask

    // Peer values at the edges: zero, equal to the extended period, and far above it.
    task automatic test_peer_extremes();
        send_item(awst_pkg::OP_UPDATE, 64'd1000000, 16'd0, 16'hffff);
        send_item(awst_pkg::OP_QUERY, 64'd1000000 + 64'd70000, 16'd5, 16'hfffc);
        send_item(awst_pkg::OP_UPDATE, 64'd2000000, 16'hffff, 16'd0);
        // Anchor now sits ahead of the current time.
        send_item(awst_pkg::OP_QUERY, 64'd2000500, 16'd0, 16'd0);
        send_item(awst_pkg::OP_UPDATE, 64'd3000000, 16'd64, 16'h1234);
        send_item(awst_pkg::OP_QUERY, 64'd3000000 + 64'd65535, 16'd1, 16'h1237);
        send_item(awst_pkg::OP_INIT, 64'd0, 16'd0, 16'd0);
        send_item(awst_pkg::OP_QUERY, 64'hffff_ffff_ffff_ffff, 16'h8000, 16'h8000);
    endtask

    // Folded settings: zero period with a window count whose low bits are zero,
    // then the largest period and then period one, each with an oversize count.
    task automatic test_folded_settings();
        apply_setting(10'd0, 10'h3e0);
        send_item(awst_pkg::OP_UPDATE, 64'd5000, 16'd0, 16'hffff);
        send_item(awst_pkg::OP_QUERY, 64'd5000 + 64'd3000, 16'd1, 16'd2);
        send_item(awst_pkg::OP_QUERY, 64'h0123_4567_89ab_cdef, 16'hffff, 16'd0);
        apply_setting(10'h3ff, 10'h3ff);
        send_item(awst_pkg::OP_INIT, 64'h0000_0001_0000_0000, 16'd0, 16'd0);
        send_item(awst_pkg::OP_QUERY, 64'h0000_0001_0000_0000 + 64'd16760831,
                  16'd16368, 16'd15);
        send_item(awst_pkg::OP_UPDATE, 64'h0000_0002_0000_0000, 16'hffff, 16'hffff);
        send_item(awst_pkg::OP_QUERY, 64'h0000_0002_0000_0000, 16'd16368, 16'hfff0);
        apply_setting(10'd1, 10'd17);
        send_item(awst_pkg::OP_UPDATE, 64'd100, 16'd9, 16'h5555);
        send_item(awst_pkg::OP_QUERY, 64'd100 + 64'd40000, 16'd3, 16'haaaa);
    endtask

    // Random phases: an init, then mostly queries with some init/update that walk forward
    // in time, mixed with far jumps, backward steps and opcode 3.
    task automatic test_random_tracking();
        logic [awst_pkg::CFG_DATA_W-1:0] pd, wd;
        logic [63:0] ext_tu, ext_us, far_now;
        logic [awst_pkg::PEER_W-1:0] pn, pc;
        int roll;
        for (int phase = 0; phase < 10; phase++)
        begin
            unique case (phase)
                0:
                begin
                    pd = 10'd1;
                    wd = 10'd1;
                end
                1:
                begin
                    pd = 10'h3ff;
                    wd = 10'd16;
                end
                2:
                begin
                    pd = 10'd0;
                    wd = 10'd0;
                end
                3:
                begin
                    pd = 10'd1023;
                    wd = 10'h3ff;
                end
                4:
                begin
                    pd = 10'd16;
                    wd = 10'd4;
                end
                default:
                begin
                    pd = ($urandom_range(0, 1) == 0)
                         ? awst_pkg::CFG_DATA_W'($urandom_range(1, 40))
                         : awst_pkg::CFG_DATA_W'($urandom_range(0, 1023));
                    wd = ($urandom_range(0, 3) == 0)
                         ? awst_pkg::CFG_DATA_W'($urandom_range(0, 1023))
                         : awst_pkg::CFG_DATA_W'($urandom_range(1, 16));
                end
            endcase
            apply_setting(pd, wd);
            ext_tu = eff_period() * eff_windows();
            ext_us = ext_tu << awst_pkg::US_SHIFT;
            // Anchor each phase somewhere random, now and then just below the wrap.
            time_cursor = ($urandom_range(0, 3) == 0) ? 64'hffff_ffff_fff0_0000
                                                      : {$urandom, $urandom};
            send_item(awst_pkg::OP_INIT, time_cursor, 16'($urandom), 16'($urandom));
            for (int n = 0; n < 140; n++)
            begin
                if (n % 20 == 0)
                    steady_flow = ($urandom_range(0, 3) == 0);
                roll = $urandom_range(0, 99);
                pn = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 32'(ext_tu)))
                                                 : 16'($urandom);
                pc = 16'($urandom);
                if (roll < 85)
                begin
                    // Advance, or step slightly back to land before the anchor.
                    if ($urandom_range(0, 15) == 0)
                        time_cursor = time_cursor
                                      - 64'($urandom_range(0, 32'(ext_us)));
                    else
                        time_cursor = time_cursor
                                      + 64'($urandom_range(0, 32'(ext_us) * 3));
                end
                far_now = {$urandom, $urandom};
                if (roll < 8)
                    send_item(awst_pkg::OP_INIT, time_cursor, pn, pc);
                else if (roll < 28)
                    send_item(awst_pkg::OP_UPDATE, time_cursor, pn, pc);
                else if (roll < 85)
                    send_item(awst_pkg::OP_QUERY, time_cursor, pn, pc);
                else if (roll < 90)
                    send_item(awst_pkg::OP_QUERY, far_now, pn, pc);
                else if (roll < 93)
                    send_item(awst_pkg::OP_UPDATE, far_now, 16'($urandom), pc);
                else
                    send_item(OP_SPARE, ($urandom_range(0, 1) == 0) ? far_now : time_cursor,
                              pn, pc);
            end
            steady_flow = 1'b0;
        end
    endtask

    // Main sequence: reset, directed checks, random phases, drain and verdict.
    initial
    begin
        item_ch.valid                <= 1'b0;
        item_ch.opcode               <= awst_pkg::OP_QUERY;
        item_ch.now_us               <= '0;
        item_ch.peer_time_to_next_tu <= '0;
        item_ch.peer_counter         <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= awst_pkg::CFG_PERIOD;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        shadow_period    = awst_pkg::RESET_PERIOD;
        shadow_windows   = awst_pkg::RESET_WINDOWS;
        shadow_anchor_us = '0;
        shadow_counter   = '0;
        mismatch_count   = 0;
        steady_flow      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_peer_extremes();
        test_folded_settings();
        test_random_tracking();

        // Let the last item finish and watch for strays after it.
        drain_block();
        repeat (200) @(posedge clk);
        if (pending_reports.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
